// ===== rtl/aclc_pkg.sv =====
// Shared types and constants for the auxiliary core lifecycle controller.
`default_nettype none

package aclc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 4;
  localparam int unsigned AddrW = 5;

  localparam logic [DataW-1:0] TcmBaseRst    = 32'h007F_8000;
  localparam logic [DataW-1:0] OcramFirstRst = 32'h0091_0000;
  localparam logic [DataW-1:0] OcramLastRst  = 32'h0091_0000 + 32'h0000_EFFF;
  localparam logic [DataW-1:0] DramFirstRst  = 32'h0000_0000;
  localparam logic [DataW-1:0] DramLastRst   = 32'h0000_0000;
  localparam logic [DataW-1:0] LoadAddrRst   = 32'h007F_8000;

  typedef enum logic [KindW-1:0] {
    KIND_START      = 4'd0,
    KIND_STOP       = 4'd1,
    KIND_PAUSE      = 4'd2,
    KIND_CONTINUE   = 4'd3,
    KIND_OFF        = 4'd4,
    KIND_RUN_STORED = 4'd5,
    KIND_RUN_AT     = 4'd6,
    KIND_SET_ADDR   = 4'd7,
    KIND_QUERY      = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_STOPPED = 2'd1,
    ST_RUNNING = 2'd2,
    ST_PAUSED  = 2'd3
  } core_state_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_DENIED  = 2'd1,
    RES_BADADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_TCM_BASE    = 3'd0,
    REG_OCRAM_FIRST = 3'd1,
    REG_OCRAM_LAST  = 3'd2,
    REG_DRAM_FIRST  = 3'd3,
    REG_DRAM_LAST   = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/aux_core_lifecycle_controller.sv =====
// An accepted command is held in the command register, then moves into the result register once it has room.
// Throughput: one command per cycle while out_ready_i takes results; the command register and the result register
//   each advance whenever the stage behind them has room, so stalls do not bubble.
// The core state and load address update in the decode stage, in command order.
// Reset (rst_ni low, asynchronous): core off, load address 0x007F8000, both stages
//   empty, configuration registers at their documented defaults.
`default_nettype none

module aux_core_lifecycle_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [aclc_pkg::KindW-1:0]    kind_i,
  input  wire logic [aclc_pkg::DataW-1:0]    target_address_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [1:0]                         core_state_o,
  output logic                               hold_in_reset_o,
  output logic                               clock_on_o,
  output logic                               core_enabled_o,
  output logic                               copy_vector_o,
  output logic [aclc_pkg::DataW-1:0]         copy_source_o,
  output logic [aclc_pkg::DataW-1:0]         load_address_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aclc_pkg::AddrW-1:0]    paddr,
  input  wire logic [aclc_pkg::DataW-1:0]    pwdata,
  output logic [aclc_pkg::DataW-1:0]         prdata,
  output logic                               pready
);
  import aclc_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [DataW-1:0] tcm_base_q, ocram_first_q, ocram_last_q, dram_first_q, dram_last_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcm_base_q    <= TcmBaseRst;
      ocram_first_q <= OcramFirstRst;
      ocram_last_q  <= OcramLastRst;
      dram_first_q  <= DramFirstRst;
      dram_last_q   <= DramLastRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TCM_BASE:    tcm_base_q    <= pwdata;
        REG_OCRAM_FIRST: ocram_first_q <= pwdata;
        REG_OCRAM_LAST:  ocram_last_q  <= pwdata;
        REG_DRAM_FIRST:  dram_first_q  <= pwdata;
        REG_DRAM_LAST:   dram_last_q   <= pwdata;
        default: ;  // holes in the map ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TCM_BASE:    prdata = tcm_base_q;
      REG_OCRAM_FIRST: prdata = ocram_first_q;
      REG_OCRAM_LAST:  prdata = ocram_last_q;
      REG_DRAM_FIRST:  prdata = dram_first_q;
      REG_DRAM_LAST:   prdata = dram_last_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Handshake: command register feeding result register
  // ---------------------------------------------------------------
  logic             cmd_valid_q;
  logic [KindW-1:0] kind_q;
  logic [DataW-1:0] target_q;
  logic             out_valid_q;
  logic             res_load;   // result register can take a new result
  logic             cmd_fire;   // command in decode moves into result register
  logic             in_acc;

  assign res_load   = ~out_valid_q | out_ready_i;
  assign cmd_fire   = cmd_valid_q & res_load;
  assign in_ready_o = ~cmd_valid_q | res_load;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_acc) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_fire) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q   <= kind_i;
      target_q <= target_address_i;
    end
  end

  // ---------------------------------------------------------------
  // Core state machine and stored load address
  // ---------------------------------------------------------------
  core_state_e      core_state_q, core_state_d;
  logic [DataW-1:0] load_addr_q, load_addr_d;
  logic [DataW-1:0] boot_addr;
  logic             boot_zero, boot_is_tcm, addr_ok;

  assign boot_addr   = (kind_q == KIND_RUN_STORED) ? load_addr_q : target_q;
  assign boot_zero   = (boot_addr == '0);
  assign boot_is_tcm = (boot_addr == tcm_base_q);
  // empty window when first > last falls out of the two compares
  assign addr_ok     = (target_q == tcm_base_q)
                     | ((ocram_first_q <= target_q) & (target_q <= ocram_last_q))
                     | ((dram_first_q <= target_q) & (target_q <= dram_last_q));

  // next state
  always_comb begin
    core_state_d = core_state_q;
    load_addr_d  = load_addr_q;
    unique case (kind_q)
      KIND_START:    if (core_state_q == ST_OFF) core_state_d = ST_STOPPED;
      KIND_STOP:     core_state_d = ST_STOPPED;
      KIND_PAUSE:    if (core_state_q == ST_RUNNING) core_state_d = ST_PAUSED;
      KIND_CONTINUE: if (core_state_q == ST_PAUSED) core_state_d = ST_RUNNING;
      KIND_OFF:      core_state_d = ST_OFF;
      KIND_RUN_STORED, KIND_RUN_AT: begin
        // a run always passes through stopped; a zero boot address parks it there
        core_state_d = boot_zero ? ST_STOPPED : ST_RUNNING;
      end
      KIND_SET_ADDR: if (addr_ok) load_addr_d = target_q;
      default: ;
    endcase
  end

  // outputs of the decode
  status_e          status_c;
  logic             copy_c;
  logic [DataW-1:0] src_c;

  always_comb begin
    status_c = RES_OK;
    copy_c   = 1'b0;
    src_c    = '0;
    unique case (kind_q)
      KIND_START:    if (core_state_q != ST_OFF) status_c = RES_DENIED;
      KIND_STOP:     ;
      KIND_PAUSE:    if (core_state_q != ST_RUNNING) status_c = RES_DENIED;
      KIND_CONTINUE: if (core_state_q != ST_PAUSED) status_c = RES_DENIED;
      KIND_OFF:      ;
      KIND_RUN_STORED, KIND_RUN_AT: begin
        if (boot_zero) begin
          status_c = RES_BADADDR;
        end else if (!boot_is_tcm) begin
          // vector already sits at the TCM base when booting from there
          copy_c = 1'b1;
          src_c  = boot_addr;
        end
      end
      KIND_SET_ADDR: if (!addr_ok) status_c = RES_BADADDR;
      KIND_QUERY:    ;
      default:       status_c = RES_DENIED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_state_q <= ST_OFF;
      load_addr_q  <= LoadAddrRst;
    end else if (cmd_fire) begin
      core_state_q <= core_state_d;
      load_addr_q  <= load_addr_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [1:0]       status_q, state_q;
  logic             hold_q, clk_on_q, enable_q, copy_q;
  logic [DataW-1:0] src_q, load_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= cmd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      status_q   <= status_c;
      state_q    <= core_state_d;
      hold_q     <= (core_state_d == ST_OFF) | (core_state_d == ST_STOPPED);
      clk_on_q   <= (core_state_d == ST_STOPPED) | (core_state_d == ST_RUNNING);
      enable_q   <= (core_state_d != ST_OFF);
      copy_q     <= copy_c;
      src_q      <= src_c;
      load_out_q <= load_addr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign core_state_o    = state_q;
  assign hold_in_reset_o = hold_q;
  assign clock_on_o      = clk_on_q;
  assign core_enabled_o  = enable_q;
  assign copy_vector_o   = copy_q;
  assign copy_source_o   = src_q;
  assign load_address_o  = load_out_q;

`ifndef SYNTHESIS
  // a copy request only goes with a successful run
  a_copy_means_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && copy_vector_o) |-> (status_o == RES_OK && core_state_o == ST_RUNNING))
    else $error("copy request without successful run");

  // no copy source leaks out with a failed command
  a_bad_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != RES_OK) |-> (!copy_vector_o && copy_source_o == '0))
    else $error("copy on failed command");

  // drive bits agree with the reported state
  a_drive_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (core_enabled_o == (core_state_o != ST_OFF)
                     && hold_in_reset_o == (core_state_o == ST_OFF || core_state_o == ST_STOPPED)))
    else $error("drive bits inconsistent with state");

  // state only moves when a command leaves decode
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_fire |=> ($stable(core_state_q) && $stable(load_addr_q)))
    else $error("core state changed without a command");

  // an empty decode stage never blocks the command channel
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_q |-> in_ready_o)
    else $error("command channel stalled with empty decode");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the auxiliary core lifecycle controller.
`timescale 1ns / 1ps

module tb;
  import aclc_pkg::*;

  localparam int unsigned RandPerPhase = 130;
  localparam int unsigned LongHold     = 64;
  localparam int unsigned MaxReports   = 10;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] target;
  } command_t;

  typedef struct packed {
    status_e          status;
    core_state_e      state;
    logic             hold;
    logic             clk_on;
    logic             enabled;
    logic             copy;
    logic [DataW-1:0] src;
    logic [DataW-1:0] load;
  } outcome_t;

  // clock, reset and every block input start at known values
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cmd_valid   = 1'b0;
  logic [KindW-1:0] cmd_kind    = '0;
  logic [DataW-1:0] cmd_target  = '0;
  logic             rsp_ready   = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;

  logic             in_ready;
  logic             out_valid;
  logic [1:0]       status;
  logic [1:0]       core_state;
  logic             hold_in_reset;
  logic             clock_on;
  logic             core_enabled;
  logic             copy_vector;
  logic [DataW-1:0] copy_source;
  logic [DataW-1:0] load_address;
  logic [DataW-1:0] prdata;
  logic             pready;

  aux_core_lifecycle_controller DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (cmd_valid),
    .in_ready_o       (in_ready),
    .kind_i           (cmd_kind),
    .target_address_i (cmd_target),
    .out_valid_o      (out_valid),
    .out_ready_i      (rsp_ready),
    .status_o         (status),
    .core_state_o     (core_state),
    .hold_in_reset_o  (hold_in_reset),
    .clock_on_o       (clock_on),
    .core_enabled_o   (core_enabled),
    .copy_vector_o    (copy_vector),
    .copy_source_o    (copy_source),
    .load_address_o   (load_address),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Predictor state: core state, stored load address and a shadow of the
  // configuration registers, updated in transaction order.
  core_state_e      model_state = ST_OFF;
  logic [DataW-1:0] model_load  = LoadAddrRst;
  logic [DataW-1:0] cfg_shadow [0:4];

  command_t    pending_q [$];
  outcome_t    expected_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;

  initial begin
    cfg_shadow[REG_TCM_BASE]    = TcmBaseRst;
    cfg_shadow[REG_OCRAM_FIRST] = OcramFirstRst;
    cfg_shadow[REG_OCRAM_LAST]  = OcramLastRst;
    cfg_shadow[REG_DRAM_FIRST]  = DramFirstRst;
    cfg_shadow[REG_DRAM_LAST]   = DramLastRst;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Runs one command through the lifecycle rules and returns its outcome.
  function automatic outcome_t apply_command(logic [KindW-1:0] kind, logic [DataW-1:0] target);
    outcome_t         o;
    core_state_e      nxt;
    logic [DataW-1:0] boot;
    o        = '0;
    o.status = RES_OK;
    nxt      = model_state;
    case (kind)
      KIND_START: begin
        if (model_state == ST_OFF) nxt = ST_STOPPED;
        else o.status = RES_DENIED;
      end
      KIND_STOP: nxt = ST_STOPPED;
      KIND_PAUSE: begin
        if (model_state == ST_RUNNING) nxt = ST_PAUSED;
        else o.status = RES_DENIED;
      end
      KIND_CONTINUE: begin
        if (model_state == ST_PAUSED) nxt = ST_RUNNING;
        else o.status = RES_DENIED;
      end
      KIND_OFF: nxt = ST_OFF;
      KIND_RUN_STORED, KIND_RUN_AT: begin
        // a run always passes through stopped; a zero boot address ends there
        boot = (kind == KIND_RUN_STORED) ? model_load : target;
        nxt  = ST_STOPPED;
        if (boot == '0) begin
          o.status = RES_BADADDR;
        end else begin
          if (boot != cfg_shadow[REG_TCM_BASE]) begin
            o.copy = 1'b1;
            o.src  = boot;
          end
          nxt = ST_RUNNING;
        end
      end
      KIND_SET_ADDR: begin
        if (target == cfg_shadow[REG_TCM_BASE] ||
            (cfg_shadow[REG_OCRAM_FIRST] <= target && target <= cfg_shadow[REG_OCRAM_LAST]) ||
            (cfg_shadow[REG_DRAM_FIRST] <= target && target <= cfg_shadow[REG_DRAM_LAST])) begin
          model_load = target;
        end else begin
          o.status = RES_BADADDR;
        end
      end
      KIND_QUERY: ;
      default: o.status = RES_DENIED;
    endcase
    model_state = nxt;
    o.state     = nxt;
    o.hold      = (nxt == ST_OFF) || (nxt == ST_STOPPED);
    o.clk_on    = (nxt == ST_STOPPED) || (nxt == ST_RUNNING);
    o.enabled   = (nxt != ST_OFF);
    o.load      = model_load;
    return o;
  endfunction

  // Command driver: holds each transaction until accepted, then waits a
  // random gap; occasional bursts go back to back.
  int unsigned gap_cnt    = 0;
  int unsigned burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    command_t    nxt_cmd;
    int unsigned r;
    if (!rst_ni) begin
      cmd_valid  <= 1'b0;
      cmd_kind   <= '0;
      cmd_target <= '0;
      gap_cnt    <= 0;
      burst_left <= 0;
    end else begin
      if (cmd_valid && in_ready) begin
        expected_q.push_back(apply_command(cmd_kind, cmd_target));
      end
      if (!cmd_valid || in_ready) begin
        if (gap_cnt != 0) begin
          cmd_valid <= 1'b0;
          gap_cnt   <= gap_cnt - 1;
        end else if (pending_q.size() != 0) begin
          nxt_cmd    = pending_q.pop_front();
          cmd_valid  <= 1'b1;
          cmd_kind   <= nxt_cmd.kind;
          cmd_target <= nxt_cmd.target;
          if (burst_left != 0) begin
            burst_left <= burst_left - 1;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 5) burst_left <= $urandom_range(15, 40);
            else if (r < 55) gap_cnt <= 0;
            else if (r < 88) gap_cnt <= $urandom_range(1, 3);
            else if (r < 97) gap_cnt <= $urandom_range(4, 12);
            else gap_cnt <= $urandom_range(20, 50);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random short and long stalls, stretches of steady
  // ready, and two long hold-offs so the pipeline fills and backs up.
  int unsigned stall_left  = 0;
  int unsigned steady_left = 0;
  int unsigned long_holds  = 0;

  always @(posedge clk_i or negedge rst_ni) begin : rsp_receiver
    int unsigned r;
    if (!rst_ni) begin
      rsp_ready   <= 1'b0;
      stall_left  <= 0;
      steady_left <= 0;
      long_holds  <= 0;
    end else if ((long_holds == 0 && results_seen >= 80) ||
                 (long_holds == 1 && results_seen >= 420)) begin
      rsp_ready  <= 1'b0;
      stall_left <= LongHold;
      long_holds <= long_holds + 1;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady_left != 0) begin
      rsp_ready   <= 1'b1;
      steady_left <= steady_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) steady_left <= $urandom_range(20, 60);
      else if (r < 30) stall_left <= $urandom_range(1, 3);
      else if (r < 33) stall_left <= $urandom_range(8, 40);
    end
  end

  task automatic note_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Result monitor: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : rsp_monitor
    outcome_t want;
    if (rst_ni && out_valid && rsp_ready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        note_mismatch("result with nothing outstanding", DataW'(status), '0);
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status)
          note_mismatch("status", DataW'(status), DataW'(want.status));
        if (core_state !== want.state)
          note_mismatch("core_state", DataW'(core_state), DataW'(want.state));
        if (hold_in_reset !== want.hold)
          note_mismatch("hold_in_reset", DataW'(hold_in_reset), DataW'(want.hold));
        if (clock_on !== want.clk_on)
          note_mismatch("clock_on", DataW'(clock_on), DataW'(want.clk_on));
        if (core_enabled !== want.enabled)
          note_mismatch("core_enabled", DataW'(core_enabled), DataW'(want.enabled));
        if (copy_vector !== want.copy)
          note_mismatch("copy_vector", DataW'(copy_vector), DataW'(want.copy));
        if (copy_source !== want.src) note_mismatch("copy_source", copy_source, want.src);
        if (load_address !== want.load) note_mismatch("load_address", load_address, want.load);
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(reg_idx_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_shadow[idx] = val;
  endtask

  task automatic queue_cmd(logic [KindW-1:0] kind, logic [DataW-1:0] target);
    command_t c;
    c.kind   = kind;
    c.target = target;
    pending_q.push_back(c);
  endtask

  // Sender pause: nothing left to send and every result back.
  task automatic wait_idle();
    while (pending_q.size() != 0 || cmd_valid || expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Addresses that sit on or next to the configured boundaries, plus noise.
  function automatic logic [DataW-1:0] pick_target();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    lo = cfg_shadow[REG_OCRAM_FIRST];
    hi = cfg_shadow[REG_OCRAM_LAST];
    if ($urandom_range(0, 1) == 0) begin
      lo = cfg_shadow[REG_DRAM_FIRST];
      hi = cfg_shadow[REG_DRAM_LAST];
    end
    case ($urandom_range(0, 9))
      0: return '0;
      1: return cfg_shadow[REG_TCM_BASE];
      2: return lo;
      3: return hi;
      4: return lo - 1;
      5: return hi + 1;
      // a window spanning the whole space would make the span count wrap to zero
      6: return (lo <= hi && (hi - lo) != '1) ? lo + ($urandom % (hi - lo + 1)) : $urandom;
      7: return cfg_shadow[REG_TCM_BASE] + $urandom_range(0, 2) - 1;
      8: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_kind();
    if ($urandom_range(0, 99) < 88) return KindW'($urandom_range(KIND_START, KIND_QUERY));
    return KindW'($urandom_range(KIND_QUERY + 1, 15));
  endfunction

  // Mostly full lifecycles with random addresses; now and then a step is
  // swapped for a random command, and the rest are loose commands.
  task automatic queue_random(int unsigned n);
    int unsigned      cnt;
    logic [KindW-1:0] seq [$];
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 60) begin
        seq = {};
        if ($urandom_range(0, 1)) seq.push_back(KIND_OFF);
        seq.push_back(KIND_START);
        seq.push_back(KIND_SET_ADDR);
        seq.push_back($urandom_range(0, 1) ? KIND_RUN_STORED : KIND_RUN_AT);
        seq.push_back(KIND_PAUSE);
        if ($urandom_range(0, 2) == 0) seq.push_back(KIND_QUERY);
        seq.push_back(KIND_CONTINUE);
        seq.push_back($urandom_range(0, 1) ? KIND_STOP : KIND_OFF);
        foreach (seq[i]) begin
          if ($urandom_range(0, 99) < 10) queue_cmd(pick_kind(), pick_target());
          else queue_cmd(seq[i], pick_target());
          cnt++;
        end
      end else begin
        queue_cmd(pick_kind(), pick_target());
        cnt++;
      end
    end
  endtask

  task automatic write_all(logic [DataW-1:0] tcm, logic [DataW-1:0] o_first,
                           logic [DataW-1:0] o_last, logic [DataW-1:0] d_first,
                           logic [DataW-1:0] d_last);
    cfg_write(REG_TCM_BASE, tcm);
    cfg_write(REG_OCRAM_FIRST, o_first);
    cfg_write(REG_OCRAM_LAST, o_last);
    cfg_write(REG_DRAM_FIRST, d_first);
    cfg_write(REG_DRAM_LAST, d_last);
  endtask

  initial begin : stimulus
    logic [DataW-1:0] base;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset configuration, every command, denied transitions,
    // zero and all-ones addresses, run without copy at the TCM base.
    queue_cmd(KIND_QUERY, '1);
    queue_cmd(KIND_CONTINUE, '0);
    queue_cmd(KIND_PAUSE, '0);
    queue_cmd(KIND_START, '0);
    queue_cmd(KIND_START, '0);
    queue_cmd(KIND_SET_ADDR, OcramFirstRst);
    queue_cmd(KIND_SET_ADDR, OcramLastRst + 1);
    queue_cmd(KIND_SET_ADDR, '1);
    queue_cmd(KIND_SET_ADDR, OcramLastRst);
    queue_cmd(KIND_RUN_STORED, '0);
    queue_cmd(KIND_PAUSE, '0);
    queue_cmd(KIND_PAUSE, '0);
    queue_cmd(KIND_CONTINUE, '0);
    queue_cmd(KIND_CONTINUE, '0);
    queue_cmd(KIND_RUN_AT, TcmBaseRst);
    queue_cmd(KIND_RUN_AT, '0);
    queue_cmd(KIND_RUN_AT, '1);
    queue_cmd(KIND_STOP, '0);
    queue_cmd(4'd9, '1);
    queue_cmd(4'd15, '0);
    // zero is inside the empty-looking DRAM window at reset, then fails a run
    queue_cmd(KIND_SET_ADDR, '0);
    queue_cmd(KIND_RUN_STORED, '0);
    queue_cmd(KIND_SET_ADDR, TcmBaseRst);
    queue_cmd(KIND_RUN_STORED, '0);
    queue_cmd(KIND_OFF, '1);
    queue_random(RandPerPhase);
    wait_idle();

    // every address allowed, TCM base at zero
    write_all('0, '1, '1, '0, '1);
    queue_random(RandPerPhase);
    wait_idle();

    // TCM base at the top, DRAM window empty (first above last)
    write_all('1, '0, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_1000);
    queue_random(RandPerPhase);
    wait_idle();

    // narrow random windows; a wrap leaves one empty now and then
    base = $urandom;
    write_all($urandom, base, base + $urandom_range(0, 255), $urandom, $urandom);
    cfg_write(REG_DRAM_LAST, cfg_shadow[REG_DRAM_FIRST] + $urandom_range(0, 4095));
    queue_random(RandPerPhase);
    wait_idle();

    write_all(TcmBaseRst, OcramFirstRst, OcramLastRst, DramFirstRst, DramLastRst);
    queue_random(RandPerPhase);

    while (pending_q.size() != 0 || cmd_valid) @(posedge clk_i);
    for (int i = 0; i < 5000 && expected_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0)
      note_mismatch("results never returned", DataW'(expected_q.size()), '0);

    if (mismatch_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
